### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the RTL datapath (kfp_dp).
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define KFP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define KFP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/kfp_pkg.sv
// ----------------------------------------------------------------------------
// kfp_pkg
// Types, sizes and helpers for the keyed FIFO with purge.
// ----------------------------------------------------------------------------
package kfp_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SUM_W  = ADDR_W + 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int KEY_W  = 32;
  localparam int PAY_W  = 32;   // stored payload width
  localparam int CMD_W  = 3;
  localparam int STS_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH    = 3'd0,
    CMD_POP     = 3'd1,
    CMD_PEEK    = 3'd2,
    CMD_COUNT   = 3'd3,
    CMD_PURGE   = 3'd4,
    CMD_REPLACE = 3'd5
  } cmd_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } sts_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FRONT,
    S_WALK
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // item taken this cycle
    logic front_fin;  // front entry read data is ready, finish pop/peek
    logic walk_run;   // purge/replace walk step
    logic walk_fin;   // walk complete, emit result
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic empty;
    logic walk_busy;  // reads outstanding or entries left to visit
  } dp_status_t;

  // circular slot offset entries behind head; off < DEPTH
  function automatic logic [ADDR_W-1:0] slot_at(logic [ADDR_W-1:0] head,
                                                logic [ADDR_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, head} + {1'b0, off};
    if (sum >= SUM_W'(DEPTH)) sum = sum - SUM_W'(DEPTH);
    return sum[ADDR_W-1:0];
  endfunction

endpackage

### rtl/keyed_fifo_with_purge.sv
// ----------------------------------------------------------------------------
// keyed_fifo_with_purge
// Keyed FIFO of key/payload entries with purge-by-key and key replace.
// ----------------------------------------------------------------------------
// One command item is in flight at a time. Push, count and unused codes finish
// in the accept cycle, so they run one item per cycle. Pop and peek finish in
// the front state, because the front entry comes out of the registered RAM
// read port; on an empty queue they finish in the accept cycle. Purge and
// replace walk the live entries one RAM read per cycle: after the accept cycle
// come the read steps, then a step to retire the last read and a step to post
// the result (on an empty queue only the post step). Purge compacts survivors
// toward the front through the same RAM write port. Any item also waits while
// the previous result sits stalled in the output register. The store needs no
// clearing pass after reset.
module keyed_fifo_with_purge (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [kfp_pkg::CMD_W-1:0]     cmd,
  input  logic [kfp_pkg::KEY_W-1:0]     in_key,
  input  logic [kfp_pkg::KEY_W-1:0]     in_new_key,
  input  logic [31:0]                   in_payload,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [kfp_pkg::KEY_W-1:0]     out_key,
  output logic [31:0]                   out_payload,
  output logic [kfp_pkg::CNT_W-1:0]     entry_count,
  output logic [kfp_pkg::STS_W-1:0]     status
);
  import kfp_pkg::*;

  ctrl_cmd_t  cc;
  dp_status_t dp_sts;

  kfp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .dp_sts(dp_sts), .cc(cc)
  );

  kfp_dp u_dp (
    .clk(clk), .rst(rst), .cc(cc), .dp_sts(dp_sts),
    .cmd(cmd), .in_key(in_key), .in_new_key(in_new_key), .in_payload(in_payload),
    .out_valid(out_valid), .out_stall(out_stall), .out_key(out_key),
    .out_payload(out_payload), .entry_count(entry_count), .status(status)
  );

endmodule

### rtl/kfp_ram.sv
// ----------------------------------------------------------------------------
// kfp_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module kfp_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

### rtl/kfp_ctrl.sv
// ----------------------------------------------------------------------------
// kfp_ctrl
// Command sequencer: accepts items and steps pop/peek and key walks.
// ----------------------------------------------------------------------------
module kfp_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [kfp_pkg::CMD_W-1:0]     cmd,
  input  kfp_pkg::dp_status_t           dp_sts,
  output kfp_pkg::ctrl_cmd_t            cc
);
  import kfp_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next   = state;
    cc           = '0;
    in_stall     = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall  = !dp_sts.out_free;
        cc.accept = in_valid && dp_sts.out_free;
        if (cc.accept) begin
          case (cmd_t'(cmd))
            CMD_POP, CMD_PEEK:      if (!dp_sts.empty) state_next = S_FRONT;
            CMD_PURGE, CMD_REPLACE: state_next = S_WALK;
            default:                state_next = S_IDLE;
          endcase
        end
      end
      S_FRONT: begin
        cc.front_fin = dp_sts.out_free;
        if (dp_sts.out_free) state_next = S_IDLE;
      end
      S_WALK: begin
        cc.walk_run = 1'b1;
        cc.walk_fin = !dp_sts.walk_busy && dp_sts.out_free;
        if (cc.walk_fin) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### rtl/kfp_dp.sv
// ----------------------------------------------------------------------------
// kfp_dp
// Queue datapath: pointers, key/payload stores, walk counters, result reg.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kfp_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  kfp_pkg::ctrl_cmd_t            cc,
  output kfp_pkg::dp_status_t           dp_sts,
  input  logic [kfp_pkg::CMD_W-1:0]     cmd,
  input  logic [kfp_pkg::KEY_W-1:0]     in_key,
  input  logic [kfp_pkg::KEY_W-1:0]     in_new_key,
  input  logic [31:0]                   in_payload,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [kfp_pkg::KEY_W-1:0]     out_key,
  output logic [31:0]                   out_payload,
  output logic [kfp_pkg::CNT_W-1:0]     entry_count,
  output logic [kfp_pkg::STS_W-1:0]     status
);
  import kfp_pkg::*;

  logic [ADDR_W-1:0] head, head_next;
  logic [CNT_W-1:0]  fill, fill_next;
  logic [CNT_W-1:0]  idx, idx_next;    // next entry to read in a walk
  logic [CNT_W-1:0]  wpos, wpos_next;  // compaction write position
  logic              pend, pend_next;  // read data valid for entry idx-1
  cmd_t              cmd_q;
  logic [KEY_W-1:0]  key_q, nkey_q;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              wr_key_en, wr_pay_en;
  logic [KEY_W-1:0]  wr_key, rd_key;
  logic [PAY_W-1:0]  wr_pay, rd_pay;
  logic [CNT_W-1:0]  idx_m1;

  logic              load;
  logic [KEY_W-1:0]  res_key;
  logic [31:0]       res_pay;
  logic [CNT_W-1:0]  res_cnt;
  sts_t              res_sts;

  kfp_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_key_ram (
    .clk(clk), .wr_en(wr_key_en), .wr_addr(wr_addr), .wr_data(wr_key),
    .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_key)
  );

  kfp_ram #(.WIDTH(PAY_W), .DEPTH(DEPTH)) u_pay_ram (
    .clk(clk), .wr_en(wr_pay_en), .wr_addr(wr_addr), .wr_data(wr_pay),
    .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_pay)
  );

  assign dp_sts.out_free  = !out_valid || !out_stall;
  assign dp_sts.empty     = (fill == '0);
  assign dp_sts.walk_busy = pend || (idx < fill);
  assign idx_m1           = idx - CNT_W'(1);

  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = head;
    wr_key_en = 1'b0;
    wr_pay_en = 1'b0;
    wr_addr   = slot_at(head, fill[ADDR_W-1:0]);
    wr_key    = in_key;
    wr_pay    = PAY_W'(in_payload);
    head_next = head;
    fill_next = fill;
    idx_next  = idx;
    wpos_next = wpos;
    pend_next = pend;
    load      = 1'b0;
    res_key   = '0;
    res_pay   = '0;
    res_cnt   = fill;
    res_sts   = STS_OK;

    if (cc.accept) begin
      case (cmd_t'(cmd))
        CMD_PUSH: begin
          load = 1'b1;
          if (fill == CNT_W'(DEPTH)) begin
            res_sts = STS_FULL;
          end else begin
            wr_key_en = 1'b1;
            wr_pay_en = 1'b1;
            fill_next = fill + CNT_W'(1);
            res_cnt   = fill + CNT_W'(1);
          end
        end
        CMD_POP, CMD_PEEK: begin
          if (fill == '0) begin
            load    = 1'b1;
            res_sts = STS_EMPTY;
          end else begin
            rd_en = 1'b1;
          end
        end
        CMD_PURGE, CMD_REPLACE: begin
          idx_next  = '0;
          wpos_next = '0;
          pend_next = 1'b0;
        end
        default: load = 1'b1;
      endcase
    end

    if (cc.front_fin) begin
      load    = 1'b1;
      res_key = rd_key;
      res_pay = 32'(rd_pay);
      if (cmd_q == CMD_POP) begin
        head_next = slot_at(head, ADDR_W'(1));
        fill_next = fill - CNT_W'(1);
        res_cnt   = fill - CNT_W'(1);
      end
    end

    if (cc.walk_run) begin
      // retire the entry read last cycle; its slot differs from this read
      if (pend) begin
        if (cmd_q == CMD_PURGE) begin
          if (rd_key != key_q) begin
            wr_key_en = 1'b1;
            wr_pay_en = 1'b1;
            wr_addr   = slot_at(head, wpos[ADDR_W-1:0]);
            wr_key    = rd_key;
            wr_pay    = rd_pay;
            wpos_next = wpos + CNT_W'(1);
          end
        end else if (rd_key == key_q) begin
          wr_key_en = 1'b1;
          wr_addr   = slot_at(head, idx_m1[ADDR_W-1:0]);
          wr_key    = nkey_q;
        end
      end
      if (idx < fill) begin
        rd_en     = 1'b1;
        rd_addr   = slot_at(head, idx[ADDR_W-1:0]);
        idx_next  = idx + CNT_W'(1);
        pend_next = 1'b1;
      end else begin
        pend_next = 1'b0;
      end
    end

    if (cc.walk_fin) begin
      load = 1'b1;
      if (cmd_q == CMD_PURGE) begin
        fill_next = wpos;
        res_cnt   = wpos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      fill      <= '0;
      idx       <= '0;
      wpos      <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      head <= head_next;
      fill <= fill_next;
      idx  <= idx_next;
      wpos <= wpos_next;
      pend <= pend_next;
      if (load)                        out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cc.accept) begin
      cmd_q  <= cmd_t'(cmd);
      key_q  <= in_key;
      nkey_q <= in_new_key;
    end
    if (load) begin
      out_key     <= res_key;
      out_payload <= res_pay;
      entry_count <= res_cnt;
      status      <= res_sts;
    end
  end

  `KFP_ASSERT_IMP(a_fill_max, clk, rst, 1'b1, fill <= CNT_W'(DEPTH), "fill above depth")
  `KFP_ASSERT_IMP(a_wpos_le_idx, clk, rst, cc.walk_run, wpos <= idx, "compaction ahead of walk")
  `KFP_ASSERT_NXT(a_pop_dec, clk, rst, cc.front_fin && cmd_q == CMD_POP,
                  fill == $past(fill) - CNT_W'(1), "pop did not drop fill")
  `KFP_ASSERT_IMP(a_load_free, clk, rst, load, dp_sts.out_free, "result overwrote pending item")

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for keyed_fifo_with_purge. A queue of command items
// is driven through the valid/stall input channel. Each accepted command
// is run through a local queue model, and the predicted response is held
// in order. The response channel is checked field by field against it.
// Both channels idle at random. The receiver also holds off once for a long
// stretch, and the sender pauses now and then until all responses are in.
// ----------------------------------------------------------------------------
module tb;
  import kfp_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

  localparam int SEGMENTS       = 19;
  localparam int SEG_LEN        = 100;
  localparam int HOLDOFF_AT     = 750;
  localparam int HOLDOFF_CYCLES = 250;
  localparam int CALM_LO        = 1100;
  localparam int CALM_HI        = 1400;
  localparam int STUCK_LIMIT    = 2000;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] new_key;
    logic [31:0]      payload;
    bit               wait_drain;  // hold back until every response is in
  } fifo_cmd_t;

  typedef struct {
    logic [KEY_W-1:0] key;
    logic [31:0]      payload;
    logic [CNT_W-1:0] count;
    logic [STS_W-1:0] status;
  } fifo_rsp_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [CMD_W-1:0] cmd = '0;
  logic [KEY_W-1:0] in_key = '0;
  logic [KEY_W-1:0] in_new_key = '0;
  logic [31:0]      in_payload = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [KEY_W-1:0] out_key;
  logic [31:0]      out_payload;
  logic [CNT_W-1:0] entry_count;
  logic [STS_W-1:0] status;

  keyed_fifo_with_purge DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .in_key      (in_key),
    .in_new_key  (in_new_key),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_key     (out_key),
    .out_payload (out_payload),
    .entry_count (entry_count),
    .status      (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fifo_cmd_t pend_cmds[$];
  fifo_rsp_t rsp_due[$];

  // queue model state
  logic [KEY_W-1:0] mdl_key [DEPTH];
  logic [PAY_W-1:0] mdl_pay [DEPTH];
  int mdl_head = 0;
  int mdl_fill = 0;

  bit in_fire = 1'b0;
  bit out_fire = 1'b0;
  int sent_count = 0;
  int rsp_count = 0;
  int stuck_cycles = 0;
  int fail_count = 0;
  int holdoff_left = 0;
  bit holdoff_done = 1'b0;
  bit sender_idle;

  int n_full = 0, n_empty = 0, n_purge = 0, n_replace = 0, max_fill = 0;

  task automatic predict_fifo(input logic [CMD_W-1:0] op, input logic [KEY_W-1:0] key,
                              input logic [KEY_W-1:0] nkey, input logic [31:0] pay,
                              output fifo_rsp_t rsp);
    int w;
    int p;
    int q;
    rsp = '{default: '0};
    case (op)
      CMD_PUSH: begin
        if (mdl_fill >= DEPTH) begin
          rsp.status = STS_FULL;
          n_full++;
        end else begin
          p = (mdl_head + mdl_fill) % DEPTH;
          mdl_key[p] = key;
          mdl_pay[p] = pay[PAY_W-1:0];
          mdl_fill++;
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (mdl_fill == 0) begin
          rsp.status = STS_EMPTY;
          n_empty++;
        end else begin
          rsp.key = mdl_key[mdl_head];
          rsp.payload = 32'(mdl_pay[mdl_head]);
          if (op == CMD_POP) begin
            mdl_head = (mdl_head + 1) % DEPTH;
            mdl_fill--;
          end
        end
      end
      CMD_PURGE: begin
        // survivors slide toward the front in order
        w = 0;
        for (int i = 0; i < mdl_fill; i++) begin
          p = (mdl_head + i) % DEPTH;
          if (mdl_key[p] != key) begin
            q = (mdl_head + w) % DEPTH;
            mdl_key[q] = mdl_key[p];
            mdl_pay[q] = mdl_pay[p];
            w++;
          end
        end
        mdl_fill = w;
        n_purge++;
      end
      CMD_REPLACE: begin
        for (int i = 0; i < mdl_fill; i++) begin
          p = (mdl_head + i) % DEPTH;
          if (mdl_key[p] == key) mdl_key[p] = nkey;
        end
        n_replace++;
      end
      default: ;
    endcase
    rsp.count = mdl_fill[CNT_W-1:0];
    if (mdl_fill > max_fill) max_fill = mdl_fill;
  endtask

  task automatic add_cmd(input logic [CMD_W-1:0] op, input logic [KEY_W-1:0] key,
                         input logic [KEY_W-1:0] nkey, input logic [31:0] pay,
                         input bit drain);
    fifo_cmd_t c;
    c.cmd = op;
    c.key = key;
    c.new_key = nkey;
    c.payload = pay;
    c.wait_drain = drain;
    pend_cmds.push_back(c);
  endtask

  // monitor: sample both handshakes, predict on input, check on output
  always @(posedge clk) begin
    fifo_rsp_t pred;
    fifo_rsp_t want;
    if (rst) begin
      in_fire = 1'b0;
      out_fire = 1'b0;
    end else begin
      in_fire = in_valid && !in_stall;
      out_fire = out_valid && !out_stall;
      if (in_fire) begin
        predict_fifo(cmd, in_key, in_new_key, in_payload, pred);
        rsp_due.push_back(pred);
      end
      if (out_fire) begin
        rsp_count++;
        if (rsp_due.size() == 0) begin
          $error("response with nothing outstanding: key %h payload %h count %0d status %0d",
                 out_key, out_payload, entry_count, status);
          fail_count++;
        end else begin
          want = rsp_due.pop_front();
          if (out_key !== want.key) begin
            $error("out_key: expected %h, got %h", want.key, out_key);
            fail_count++;
          end
          if (out_payload !== want.payload) begin
            $error("out_payload: expected %h, got %h", want.payload, out_payload);
            fail_count++;
          end
          if (entry_count !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, entry_count);
            fail_count++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            fail_count++;
          end
        end
      end
      if (in_fire || out_fire) stuck_cycles = 0;
      else stuck_cycles++;
    end
  end

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        void'(pend_cmds.pop_front());
        sent_count++;
      end
      if (!in_valid || in_fire) begin
        sender_idle = !(sent_count >= CALM_LO && sent_count < CALM_HI) &&
                      ($urandom_range(99) < 36);
        if (pend_cmds.size() > 0 && !sender_idle &&
            !(pend_cmds[0].wait_drain && rsp_due.size() > 0)) begin
          cmd        <= pend_cmds[0].cmd;
          in_key     <= pend_cmds[0].key;
          in_new_key <= pend_cmds[0].new_key;
          in_payload <= pend_cmds[0].payload;
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off, one calm stretch
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (holdoff_left > 0) begin
      out_stall <= 1'b1;
      holdoff_left--;
    end else if (!holdoff_done && rsp_count >= HOLDOFF_AT) begin
      holdoff_done = 1'b1;
      holdoff_left = HOLDOFF_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (rsp_count >= CALM_LO && rsp_count < CALM_HI) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 36);
    end
  end

  initial begin
    while (stuck_cycles < STUCK_LIMIT) @(posedge clk);
    $display("watchdog: no handshake for %0d cycles", STUCK_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [KEY_W-1:0] pool [4];
    logic [CMD_W-1:0] op;
    logic [KEY_W-1:0] k;
    logic [KEY_W-1:0] nk;
    int seg_kind;
    int w_push, w_pop, w_peek, w_count, w_purge, w_repl;
    int r;

    // directed: empty cases, odd codes, extremes, matching purge/replace
    add_cmd(CMD_POP,      '0, '0, '0, 1'b0);
    add_cmd(CMD_PEEK,     '0, '0, '0, 1'b0);
    add_cmd(CMD_PURGE,    '0, '0, '0, 1'b0);
    add_cmd(CMD_REPLACE,  '0, '1, '0, 1'b0);
    add_cmd(CMD_COUNT,    '0, '0, '0, 1'b0);
    add_cmd(CMD_UNUSED_6, '1, '1, '1, 1'b0);
    add_cmd(CMD_UNUSED_7, '1, '1, '1, 1'b0);
    add_cmd(CMD_PUSH,     '0, '0, '0, 1'b0);
    add_cmd(CMD_PEEK,     '0, '0, '0, 1'b0);
    add_cmd(CMD_PUSH,     '1, '0, '1, 1'b0);
    add_cmd(CMD_PUSH,     '0, '0, 32'h5a5a_a5a5, 1'b0);
    add_cmd(CMD_REPLACE,  '0, '1, '0, 1'b0);
    add_cmd(CMD_COUNT,    '0, '0, '0, 1'b0);
    add_cmd(CMD_PURGE,    32'h0001_2345, '0, '0, 1'b0);
    add_cmd(CMD_PURGE,    '1, '0, '0, 1'b0);
    add_cmd(CMD_PUSH,     32'h0000_000a, '0, 32'h1111_1111, 1'b0);
    add_cmd(CMD_PUSH,     32'h0000_000b, '0, 32'h2222_2222, 1'b0);
    add_cmd(CMD_PUSH,     32'h0000_000a, '0, 32'h3333_3333, 1'b0);
    add_cmd(CMD_PURGE,    32'h0000_000a, '0, '0, 1'b0);
    add_cmd(CMD_POP,      '0, '0, '0, 1'b0);
    add_cmd(CMD_POP,      '0, '0, '0, 1'b0);
    add_cmd(CMD_COUNT,    '0, '0, '0, 1'b0);

    // random: segments biased to fill, drain or mix, keys mostly from a pool
    for (int s = 0; s < SEGMENTS; s++) begin
      seg_kind = (s == 0) ? 0 : (s == 1) ? 1 : $urandom_range(2);
      for (int j = 0; j < 4; j++) pool[j] = $urandom;
      case (seg_kind)
        0: begin w_push = 78; w_pop = 5;  w_peek = 5;  w_count = 3; w_purge = 2;  w_repl = 4; end
        1: begin w_push = 20; w_pop = 45; w_peek = 10; w_count = 5; w_purge = 10; w_repl = 5; end
        default: begin
          w_push = 40; w_pop = 25; w_peek = 10; w_count = 5; w_purge = 8; w_repl = 8;
        end
      endcase
      for (int i = 0; i < SEG_LEN; i++) begin
        r = $urandom_range(99);
        if (r < w_push) op = CMD_PUSH;
        else if (r < w_push + w_pop) op = CMD_POP;
        else if (r < w_push + w_pop + w_peek) op = CMD_PEEK;
        else if (r < w_push + w_pop + w_peek + w_count) op = CMD_COUNT;
        else if (r < w_push + w_pop + w_peek + w_count + w_purge) op = CMD_PURGE;
        else if (r < w_push + w_pop + w_peek + w_count + w_purge + w_repl) op = CMD_REPLACE;
        else op = $urandom_range(1) ? CMD_UNUSED_6 : CMD_UNUSED_7;
        k  = ($urandom_range(99) < 80) ? pool[$urandom_range(3)] : $urandom;
        nk = ($urandom_range(99) < 60) ? pool[$urandom_range(3)] : $urandom;
        add_cmd(op, k, nk, $urandom, (i == 0) && (s % 5 == 0) && (s > 0));
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pend_cmds.size() != 0 || rsp_due.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    if (rsp_due.size() != 0) begin
      $error("%0d responses never arrived", rsp_due.size());
      fail_count++;
    end

    $display("Ran %0d commands, %0d responses; peak fill %0d of %0d", sent_count, rsp_count,
             max_fill, DEPTH);
    $display("Refused pushes when full: %0d, empty pops/peeks: %0d, purges: %0d, replaces: %0d",
             n_full, n_empty, n_purge, n_replace);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### keyed_fifo_with_purge.f
+incdir+rtl
rtl/kfp_pkg.sv
rtl/kfp_ram.sv
rtl/kfp_ctrl.sv
rtl/kfp_dp.sv
rtl/keyed_fifo_with_purge.sv
dv/tb.sv
